// ----- design/mpid_pkg.sv -----
// Shared definitions for the motor PID controller: field widths,
// configuration register map and reset values. No dependencies.
package mpid_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF = 32;
	localparam int GAIN_FRAC_DEF = 8;

	localparam int GAIN_W = 16;
	localparam int OFFSET_W = 15;
	localparam int PERIOD_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GAIN_P = 4'd0,
		REG_GAIN_I = 4'd1,
		REG_GAIN_D = 4'd2,
		REG_LOW_LIMIT = 4'd3,
		REG_HIGH_LIMIT = 4'd4,
		REG_DEADBAND = 4'd5,
		REG_SPEED_MODE = 4'd6,
		REG_SAMPLE_PERIOD = 4'd7
	} reg_index_t;

	localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd256;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;
	localparam int LOW_LIMIT_RST = -255;
	localparam int HIGH_LIMIT_RST = 255;

endpackage

// ----- design/mpid_cfg_regs.sv -----
// Configuration register file of the motor PID controller.
// Depends on mpid_pkg for the register map, widths and reset values.
module mpid_cfg_regs #(
	parameter int DATA_WIDTH = mpid_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mpid_pkg::CFG_ADDR_W-1:0]       cfg_index,
	input  logic [mpid_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic signed [mpid_pkg::GAIN_W-1:0]    gain_p,
	output logic signed [mpid_pkg::GAIN_W-1:0]    gain_i,
	output logic signed [mpid_pkg::GAIN_W-1:0]    gain_d,
	output logic signed [DATA_WIDTH:0]            low_limit,
	output logic signed [DATA_WIDTH:0]            high_limit,
	output logic [mpid_pkg::OFFSET_W-1:0]         deadband_offset,
	output logic                                  speed_mode,
	output logic [mpid_pkg::PERIOD_W-1:0]         sample_period
);

	localparam int LIM_W = DATA_WIDTH + 1;

	logic signed [LIM_W-1:0] limit_wdata;

	assign cfg_ready = 1'b1;
	// Limits keep one extra bit so the reset limits stay exact at narrow widths.
	assign limit_wdata = LIM_W'($signed(cfg_data[DATA_WIDTH-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p <= mpid_pkg::GAIN_P_RST;
			gain_i <= mpid_pkg::GAIN_I_RST;
			gain_d <= mpid_pkg::GAIN_D_RST;
			low_limit <= LIM_W'(mpid_pkg::LOW_LIMIT_RST);
			high_limit <= LIM_W'(mpid_pkg::HIGH_LIMIT_RST);
			deadband_offset <= '0;
			speed_mode <= 1'b0;
			sample_period <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mpid_pkg::REG_GAIN_P: begin
					gain_p <= $signed(cfg_data[mpid_pkg::GAIN_W-1:0]);
				end
				mpid_pkg::REG_GAIN_I: begin
					gain_i <= $signed(cfg_data[mpid_pkg::GAIN_W-1:0]);
				end
				mpid_pkg::REG_GAIN_D: begin
					gain_d <= $signed(cfg_data[mpid_pkg::GAIN_W-1:0]);
				end
				mpid_pkg::REG_LOW_LIMIT: begin
					low_limit <= limit_wdata;
				end
				mpid_pkg::REG_HIGH_LIMIT: begin
					high_limit <= limit_wdata;
				end
				mpid_pkg::REG_DEADBAND: begin
					deadband_offset <= cfg_data[mpid_pkg::OFFSET_W-1:0];
				end
				mpid_pkg::REG_SPEED_MODE: begin
					speed_mode <= cfg_data[0];
				end
				mpid_pkg::REG_SAMPLE_PERIOD: begin
					sample_period <= cfg_data[mpid_pkg::PERIOD_W-1:0];
				end
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

endmodule

// ----- design/mpid_datapath.sv -----
// Single-pass PID arithmetic: sample gate, integral with clamping
// anti-windup, weighted sum, deadband offset and output clamp.
// Depends on mpid_pkg for field widths.
module mpid_datapath #(
	parameter int DATA_WIDTH = mpid_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH = mpid_pkg::ACC_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = mpid_pkg::GAIN_FRAC_DEF
) (
	input  logic [mpid_pkg::TIME_W-1:0]           time_ms,
	input  logic signed [DATA_WIDTH-1:0]          target,
	input  logic signed [DATA_WIDTH-1:0]          measured,
	input  logic signed [DATA_WIDTH:0]            last_drive,
	input  logic signed [ACC_WIDTH-1:0]           integral_sum,
	input  logic signed [DATA_WIDTH-1:0]          last_measured,
	input  logic [mpid_pkg::TIME_W-1:0]           last_update_time,
	input  logic signed [mpid_pkg::GAIN_W-1:0]    gain_p,
	input  logic signed [mpid_pkg::GAIN_W-1:0]    gain_i,
	input  logic signed [mpid_pkg::GAIN_W-1:0]    gain_d,
	input  logic signed [DATA_WIDTH:0]            low_limit,
	input  logic signed [DATA_WIDTH:0]            high_limit,
	input  logic [mpid_pkg::OFFSET_W-1:0]         deadband_offset,
	input  logic                                  speed_mode,
	input  logic [mpid_pkg::PERIOD_W-1:0]         sample_period,
	output logic                                  emit,
	output logic signed [DATA_WIDTH:0]            drive_next,
	output logic signed [ACC_WIDTH-1:0]           integral_next
);

	localparam int LIM_W = DATA_WIDTH + 1;
	localparam int MX = (ACC_WIDTH > DATA_WIDTH + 1) ? ACC_WIDTH : DATA_WIDTH + 1;
	// gain times widest term, three terms summed
	localparam int SUM_W = MX + mpid_pkg::GAIN_W + 2;
	localparam int DB_W = SUM_W + 1;
	localparam logic signed [SUM_W-1:0] ACC_MAX =
		{{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [SUM_W-1:0] FRAC_MASK =
		(SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);

	logic [mpid_pkg::TIME_W-1:0] elapsed;
	logic signed [SUM_W-1:0] err;
	logic signed [SUM_W-1:0] deriv;
	logic signed [SUM_W-1:0] isum;
	logic signed [SUM_W-1:0] isum_sat;
	logic signed [SUM_W-1:0] integ;
	logic signed [SUM_W-1:0] wsum;
	logic signed [SUM_W-1:0] quot;
	logic signed [DB_W-1:0] offset_ext;
	logic signed [DB_W-1:0] drive_raw;
	logic signed [DB_W-1:0] hi_ext;
	logic signed [DB_W-1:0] lo_ext;
	logic in_band;
	logic offset_up;

	always_comb begin
		elapsed = time_ms - last_update_time;
		emit = elapsed >= {{(mpid_pkg::TIME_W-mpid_pkg::PERIOD_W){1'b0}}, sample_period};

		err = SUM_W'(target) - SUM_W'(measured);
		deriv = SUM_W'(last_measured) - SUM_W'(measured);

		// integrate only while the previous drive was off both limits
		in_band = (last_drive < high_limit) && (last_drive > low_limit);
		isum = SUM_W'(integral_sum) + err;
		if (isum > ACC_MAX) begin
			isum_sat = ACC_MAX;
		end else if (isum < ACC_MIN) begin
			isum_sat = ACC_MIN;
		end else begin
			isum_sat = isum;
		end
		integ = in_band ? isum_sat : SUM_W'(integral_sum);
		integral_next = integ[ACC_WIDTH-1:0];

		wsum = SUM_W'(gain_p) * err + SUM_W'(gain_i) * integ + SUM_W'(gain_d) * deriv;
		// bias negative sums so the shift truncates toward zero
		quot = (wsum + (wsum[SUM_W-1] ? FRAC_MASK : SUM_W'(0))) >>> GAIN_FRAC_BITS;

		offset_ext = $signed({{(DB_W-mpid_pkg::OFFSET_W){1'b0}}, deadband_offset});
		offset_up = speed_mode ? (target > 0) : (err > 0);
		drive_raw = offset_up ? (DB_W'(quot) + offset_ext) : (DB_W'(quot) - offset_ext);

		hi_ext = DB_W'(high_limit);
		lo_ext = DB_W'(low_limit);
		// high limit is tested first: on crossed limits, sums above it get the high limit, all others the low
		if (drive_raw > hi_ext) begin
			drive_next = high_limit;
		end else if (drive_raw < lo_ext) begin
			drive_next = low_limit;
		end else begin
			drive_next = drive_raw[LIM_W-1:0];
		end
	end

endmodule

// ----- design/motor_pid_controller_top.sv -----
// Top level of the motor PID controller: input register, controller state,
// result register and handshakes. Depends on mpid_pkg, mpid_cfg_regs and
// mpid_datapath.

// Motor PID controller with derivative on measurement, clamping anti-windup
// and deadband offset. Each item transfer carries a time stamp, a target and
// a measurement; an item arriving less than sample_period ms after the last
// update is consumed without a result, otherwise exactly one drive_output
// follows. An accepted item is held in the input register and its result is
// registered from there. One item is taken each cycle unless it has a result
// and an unread one waits on out_ready: the whole update, including the
// three gain multiplies, is one combinational pass from the input register
// to the result register, because each update needs the integral and drive
// left by the one before. Configuration writes are taken on any cycle and
// are meant to be issued only while the controller is idle.
module motor_pid_controller_top #(
	parameter int DATA_WIDTH = mpid_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH = mpid_pkg::ACC_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = mpid_pkg::GAIN_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mpid_pkg::CFG_ADDR_W-1:0]  cfg_index,
	input  logic [mpid_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mpid_pkg::TIME_W-1:0]      time_ms,
	input  logic signed [DATA_WIDTH-1:0]     target,
	input  logic signed [DATA_WIDTH-1:0]     measured,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [DATA_WIDTH-1:0]     drive_output
);

	localparam int LIM_W = DATA_WIDTH + 1;

	logic signed [mpid_pkg::GAIN_W-1:0] gain_p;
	logic signed [mpid_pkg::GAIN_W-1:0] gain_i;
	logic signed [mpid_pkg::GAIN_W-1:0] gain_d;
	logic signed [LIM_W-1:0] low_limit;
	logic signed [LIM_W-1:0] high_limit;
	logic [mpid_pkg::OFFSET_W-1:0] deadband_offset;
	logic speed_mode;
	logic [mpid_pkg::PERIOD_W-1:0] sample_period;

	logic valid_s1;
	logic [mpid_pkg::TIME_W-1:0] time_s1;
	logic signed [DATA_WIDTH-1:0] target_s1;
	logic signed [DATA_WIDTH-1:0] measured_s1;

	logic signed [LIM_W-1:0] last_drive_q;
	logic signed [ACC_WIDTH-1:0] integral_q;
	logic signed [DATA_WIDTH-1:0] last_measured_q;
	logic [mpid_pkg::TIME_W-1:0] last_time_q;

	logic out_valid_q;
	logic signed [DATA_WIDTH-1:0] drive_q;

	logic emit;
	logic signed [LIM_W-1:0] drive_next;
	logic signed [ACC_WIDTH-1:0] integral_next;
	logic advance;

	mpid_cfg_regs #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.gain_p(gain_p),
		.gain_i(gain_i),
		.gain_d(gain_d),
		.low_limit(low_limit),
		.high_limit(high_limit),
		.deadband_offset(deadband_offset),
		.speed_mode(speed_mode),
		.sample_period(sample_period)
	);

	mpid_datapath #(
		.DATA_WIDTH(DATA_WIDTH),
		.ACC_WIDTH(ACC_WIDTH),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_datapath (
		.time_ms(time_s1),
		.target(target_s1),
		.measured(measured_s1),
		.last_drive(last_drive_q),
		.integral_sum(integral_q),
		.last_measured(last_measured_q),
		.last_update_time(last_time_q),
		.gain_p(gain_p),
		.gain_i(gain_i),
		.gain_d(gain_d),
		.low_limit(low_limit),
		.high_limit(high_limit),
		.deadband_offset(deadband_offset),
		.speed_mode(speed_mode),
		.sample_period(sample_period),
		.emit(emit),
		.drive_next(drive_next),
		.integral_next(integral_next)
	);

	// A skipped item needs no room in the result register.
	assign advance = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign drive_output = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_s1 <= time_ms;
			target_s1 <= target;
			measured_s1 <= measured;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_drive_q <= '0;
			integral_q <= '0;
			last_measured_q <= '0;
			last_time_q <= '0;
		end else if (advance && emit) begin
			last_drive_q <= drive_next;
			integral_q <= integral_next;
			last_measured_q <= measured_s1;
			last_time_q <= time_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			drive_q <= drive_next[DATA_WIDTH-1:0];
		end
	end

endmodule
